// ----- design/pps_pkg.sv -----
// pps_pkg: shared types, constants and tables of the pure pursuit steering block
// depends on nothing; used by every module of the block

package pps_pkg;

  localparam int PPS_MAX_POINTS = 4096;
  localparam int PPS_QUEUE_DEPTH = 4;
  localparam int PPS_CORDIC_STEPS = 24;
  localparam logic [15:0] PPS_STEER_LIMIT = 16'd16200;
  localparam logic [15:0] PPS_DEG_SCALE = 16'd46080;
  localparam logic [31:0] PPS_CORDIC_GAIN = 32'd652032874;

  typedef enum logic [2:0] {
    REG_LOOKAHEAD   = 3'd0,
    REG_WHEELBASE   = 3'd1,
    REG_STEER_GAIN  = 3'd2,
    REG_DRIVE_SPEED = 3'd3,
    REG_WINDOW_BACK = 3'd4,
    REG_WINDOW_AHD  = 3'd5
  } reg_index_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_POSE = 1'b1
  } opcode_t;

  typedef enum logic {
    CORDIC_VEC = 1'b0,
    CORDIC_ROT = 1'b1
  } cordic_mode_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
  } in_t;

  typedef struct packed {
    logic signed [14:0] steer_angle;
    logic [7:0]         speed_cmd;
    logic [11:0]        nearest_point;
    logic [11:0]        target_point;
  } out_t;

  typedef struct packed {
    logic [15:0] lookahead_dist;
    logic [11:0] wheelbase;
    logic [9:0]  steer_gain;
    logic [7:0]  drive_speed;
    logic [7:0]  window_back;
    logic [7:0]  window_ahead;
  } cfg_t;

  // queue entry: item already sorted into load or pose
  typedef struct packed {
    logic               is_pose;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
  } item_t;

  // arctangent of 2^-i as a 32 bit binary angle
  function automatic logic [31:0] pps_atan(input logic [4:0] step);
    logic [31:0] a;
    unique case (step)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/pps_front.sv -----
// pps_front: input side, accepts transactions, tags them and queues them
// depends on pps_pkg

module pps_front import pps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  localparam int QAW = $clog2(PPS_QUEUE_DEPTH);

  item_t           slots [PPS_QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    fill;
  logic            push;
  logic            pop;
  item_t           tagged_item;

  assign in_ready = (fill != (QAW+1)'(PPS_QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_item   = slots[rd_ptr];

  always_comb begin
    tagged_item.is_pose = (in_data.opcode == OP_POSE);
    tagged_item.pos_x   = in_data.pos_x;
    tagged_item.pos_y   = in_data.pos_y;
    tagged_item.heading = in_data.heading;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= tagged_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- design/pps_cordic.sv -----
// pps_cordic: shared iterative cordic, vector mode (atan2) and rotation mode (sine)
// depends on pps_pkg

module pps_cordic import pps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cordic_mode_t       mode,
  input  logic signed [63:0] x_in,
  input  logic signed [63:0] y_in,
  input  logic [31:0]        theta,
  output logic               done,
  output logic [31:0]        angle,
  output logic signed [31:0] sine
);

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_t;

  localparam logic signed [63:0] NORM_HI = 64'sd1 <<< 41;
  localparam logic signed [63:0] NORM_LO = 64'sd1 <<< 40;
  localparam logic signed [63:0] Y_LIM   = 64'sd1 <<< 30;

  cstate_t            st;
  cordic_mode_t       md;
  logic signed [63:0] x;
  logic signed [63:0] y;
  logic signed [33:0] z;
  logic [31:0]        ang;
  logic               neg;
  logic [4:0]         step;
  logic signed [63:0] ax;
  logic signed [63:0] ay;
  logic signed [63:0] mx;
  logic signed [63:0] xs;
  logic signed [63:0] ys;
  logic [31:0]        at;
  logic [31:0]        th_fold;
  logic               th_neg;
  logic signed [63:0] y_clamp;

  assign ax = (x < 0) ? -x : x;
  assign ay = (y < 0) ? -y : y;
  assign mx = (ax > ay) ? ax : ay;
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = pps_atan(step);

  // fold the second and third quadrant onto the first and fourth
  assign th_neg  = (theta[31:30] == 2'b01) || (theta[31:30] == 2'b10);
  assign th_fold = th_neg ? (theta - 32'h8000_0000) : theta;

  always_comb begin
    if (y > Y_LIM) begin
      y_clamp = Y_LIM;
    end else if (y < -Y_LIM) begin
      y_clamp = -Y_LIM;
    end else begin
      y_clamp = y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= C_IDLE;
      done <= 1'b0;
    end else begin
      // done on a zero vector at start, or on the last iteration
      done <= ((st == C_IDLE) && start && (mode == CORDIC_VEC) && (x_in == 0) && (y_in == 0))
              || ((st == C_ITER) && (step == 5'(PPS_CORDIC_STEPS - 1)));
      unique case (st)
        C_IDLE: begin
          if (start) begin
            md   <= mode;
            step <= '0;
            if (mode == CORDIC_ROT) begin
              x   <= 64'(PPS_CORDIC_GAIN);
              y   <= '0;
              z   <= {{2{th_fold[31]}}, th_fold};
              neg <= th_neg;
              st  <= C_ITER;
            end else if (x_in == 0 && y_in == 0) begin
              angle <= '0;
            end else if (x_in < 0) begin
              x   <= -x_in;
              y   <= -y_in;
              ang <= 32'h8000_0000;
              st  <= C_NORM;
            end else begin
              x   <= x_in;
              y   <= y_in;
              ang <= '0;
              st  <= C_NORM;
            end
          end
        end
        C_NORM: begin
          // one shift a cycle until the larger magnitude sits in [2^40, 2^41)
          if (mx >= NORM_HI) begin
            x <= x >>> 1;
            y <= y >>> 1;
          end else if (mx < NORM_LO) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            st <= C_ITER;
          end
        end
        C_ITER: begin
          if (md == CORDIC_VEC) begin
            if (y > 0) begin
              x   <= x + ys;
              y   <= y - xs;
              ang <= ang + at;
            end else begin
              x   <= x - ys;
              y   <= y + xs;
              ang <= ang - at;
            end
          end else begin
            if (z >= 0) begin
              x <= x - ys;
              y <= y + xs;
              z <= z - $signed({2'b00, at});
            end else begin
              x <= x + ys;
              y <= y - xs;
              z <= z + $signed({2'b00, at});
            end
          end
          if (step == 5'(PPS_CORDIC_STEPS - 1)) begin
            st <= C_IDLE;
            if (md == CORDIC_VEC) begin
              if (y > 0) begin
                angle <= ang + at;
              end else begin
                angle <= ang - at;
              end
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        default: st <= C_IDLE;
      endcase
    end
  end

  // sine is taken once the last rotation step has landed
  logic signed [63:0] sine_full;
  assign sine_full = neg ? -y_clamp : y_clamp;
  assign sine      = sine_full[31:0];

endmodule

// ----- design/pps_back.sv -----
// pps_back: path store, nearest and lookahead search, distance root and steer math
// depends on pps_pkg and pps_cordic

module pps_back import pps_pkg::*; #(
  parameter int MAX_POINTS = PPS_MAX_POINTS
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  output logic  q_ready,
  input  item_t q_item,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int SW = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_DIFF, S_SQX, S_SQY, S_CMP, S_TINIT, S_SQRT,
    S_BRD, S_BDIFF, S_BEAR, S_SINE, S_MUL1, S_TSTART, S_TURN, S_MUL2, S_RND, S_FIN
  } state_t;

  state_t st;

  logic signed [31:0] path_x [MAX_POINTS];
  logic signed [31:0] path_y [MAX_POINTS];
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_y;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;

  logic [CW-1:0]      point_count;
  logic [AW-1:0]      nearest_index;
  logic [AW-1:0]      target_index;
  logic [31:0]        target_distance;
  logic               first_search;

  logic [CW-1:0]      idx;
  logic [CW-1:0]      hi;
  logic               tgt_mode;
  logic               have;
  logic [63:0]        best;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic [15:0]        hdg;

  logic [32:0]        mx;
  logic [32:0]        my;
  logic               sat;
  logic [63:0]        prod;
  logic [63:0]        dsq;

  logic [63:0]        sq_v;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [4:0]         sq_cnt;

  logic               c_start;
  cordic_mode_t       c_mode;
  logic signed [63:0] c_x;
  logic signed [63:0] c_y;
  logic [31:0]        c_theta;
  logic               c_done;
  logic [31:0]        c_angle;
  logic signed [31:0] c_sine;

  logic signed [31:0] sine;
  logic signed [45:0] num;
  logic [25:0]        kgain;
  logic signed [31:0] tang;
  logic [57:0]        mag;
  logic signed [15:0] steer;

  // window bounds from the current nearest index
  logic [CW-1:0]      lastp;
  logic [SW-1:0]      hi_sum;
  logic [CW-1:0]      hi_lim;
  logic [CW-1:0]      lo_w;
  logic [CW-1:0]      near_ext;

  assign near_ext = CW'(nearest_index);
  assign lastp    = point_count - 1'b1;
  assign hi_sum   = SW'(nearest_index) + SW'(cfg.window_ahead);
  assign hi_lim   = (hi_sum > SW'(lastp)) ? lastp : hi_sum[CW-1:0];
  assign lo_w     = (SW'(nearest_index) > SW'(cfg.window_back))
                    ? CW'(SW'(nearest_index) - SW'(cfg.window_back)) : '0;

  logic [31:0] ld2;
  assign ld2 = cfg.lookahead_dist * cfg.lookahead_dist;

  // distance pieces
  logic signed [32:0] dxs;
  logic signed [32:0] dys;
  logic [64:0]        sq_sum;
  assign dxs    = {px[31], px} - {rd_x[31], rd_x};
  assign dys    = {py[31], py} - {rd_y[31], rd_y};
  assign sq_sum = {1'b0, prod} + 65'(my[31:0] * my[31:0]);

  // integer square root step
  logic [63:0] sq_trial;
  logic [63:0] sq_res_next;
  logic [63:0] sq_v_next;
  assign sq_trial = sq_res + sq_bit;
  always_comb begin
    if (sq_v >= sq_trial) begin
      sq_v_next   = sq_v - sq_trial;
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_v_next   = sq_v;
      sq_res_next = sq_res >> 1;
    end
  end

  logic [31:0] tabs;
  logic [58:0] rnd_sum;
  logic [18:0] rnd;
  assign tabs    = (tang < 0) ? 32'(-tang) : 32'(tang);
  assign rnd_sum = {1'b0, mag} + (59'd1 << 39);
  assign rnd     = rnd_sum[58:40];

  assign q_ready = (st == S_IDLE);
  assign rd_addr = (st == S_BRD) ? target_index : idx[AW-1:0];
  assign mem_we  = (st == S_IDLE) && q_valid && !q_item.is_pose
                   && (point_count < CW'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      path_x[point_count[AW-1:0]] <= q_item.pos_x;
      path_y[point_count[AW-1:0]] <= q_item.pos_y;
    end
    rd_x <= path_x[rd_addr];
    rd_y <= path_y[rd_addr];
  end

  pps_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .mode  (c_mode),
    .x_in  (c_x),
    .y_in  (c_y),
    .theta (c_theta),
    .done  (c_done),
    .angle (c_angle),
    .sine  (c_sine)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= S_IDLE;
      point_count     <= '0;
      nearest_index   <= '0;
      target_index    <= '0;
      target_distance <= '0;
      first_search    <= 1'b1;
      out_valid       <= 1'b0;
      c_start         <= 1'b0;
    end else begin
      // cordic starts for the bearing, the sine and the steer angle
      c_start <= (st == S_BDIFF) || (st == S_TSTART) || ((st == S_BEAR) && c_done);
      if (out_valid && out_ready && (st != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (q_valid) begin
            px  <= q_item.pos_x;
            py  <= q_item.pos_y;
            hdg <= q_item.heading;
            if (!q_item.is_pose) begin
              if (point_count < CW'(MAX_POINTS)) begin
                point_count <= point_count + 1'b1;
              end
            end else if (point_count == '0) begin
              steer <= '0;
              st    <= S_FIN;
            end else begin
              have     <= 1'b0;
              tgt_mode <= 1'b0;
              first_search <= 1'b0;
              if (first_search) begin
                idx <= '0;
                hi  <= point_count;
                st  <= S_RD;
              end else begin
                idx <= lo_w;
                hi  <= hi_lim;
                st  <= (lo_w < hi_lim) ? S_RD : S_TINIT;
              end
            end
          end
        end
        S_RD: st <= S_DIFF;
        S_DIFF: begin
          mx <= (dxs < 0) ? 33'(-dxs) : 33'(dxs);
          my <= (dys < 0) ? 33'(-dys) : 33'(dys);
          st <= S_SQX;
        end
        S_SQX: begin
          sat  <= mx[32] | my[32];
          prod <= mx[31:0] * mx[31:0];
          st   <= S_SQY;
        end
        S_SQY: begin
          dsq <= (sat || sq_sum[64]) ? '1 : sq_sum[63:0];
          st  <= S_CMP;
        end
        S_CMP: begin
          if (!tgt_mode) begin
            if (!have || dsq < best) begin
              best          <= dsq;
              have          <= 1'b1;
              nearest_index <= idx[AW-1:0];
            end
            idx <= idx + 1'b1;
            st  <= ((idx + 1'b1) < hi) ? S_RD : S_TINIT;
          end else if (dsq > {32'd0, ld2}) begin
            target_index <= idx[AW-1:0];
            sq_v   <= dsq;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            sq_cnt <= 5'd31;
            st     <= S_SQRT;
          end else begin
            idx <= idx + 1'b1;
            st  <= ((idx + 1'b1) < hi) ? S_RD : S_BRD;
          end
        end
        S_TINIT: begin
          tgt_mode <= 1'b1;
          idx      <= near_ext;
          hi       <= hi_lim;
          st       <= (near_ext < hi_lim) ? S_RD : S_BRD;
        end
        S_SQRT: begin
          sq_v   <= sq_v_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt - 1'b1;
          if (sq_cnt == '0) begin
            target_distance <= sq_res_next[31:0];
            st              <= S_BRD;
          end
        end
        S_BRD: st <= S_BDIFF;
        S_BDIFF: begin
          // bearing vector: north component first, east second
          c_x     <= {{32{rd_y[31]}}, rd_y} - {{32{py[31]}}, py};
          c_y     <= {{32{rd_x[31]}}, rd_x} - {{32{px[31]}}, px};
          c_mode  <= CORDIC_VEC;
          st      <= S_BEAR;
        end
        S_BEAR: begin
          if (c_done) begin
            c_theta <= c_angle - {hdg, 16'h0000};
            c_mode  <= CORDIC_ROT;
            st      <= S_SINE;
          end
        end
        S_SINE: begin
          if (c_done) begin
            sine <= c_sine;
            if (target_distance == '0) begin
              if (c_sine > 0) begin
                steer <= $signed(PPS_STEER_LIMIT);
              end else if (c_sine < 0) begin
                steer <= -$signed(PPS_STEER_LIMIT);
              end else begin
                steer <= '0;
              end
              st <= S_FIN;
            end else begin
              st <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          num   <= $signed({1'b0, cfg.wheelbase, 1'b0}) * sine;
          kgain <= 26'(PPS_DEG_SCALE) * 26'(cfg.steer_gain);
          st    <= S_TSTART;
        end
        S_TSTART: begin
          c_x     <= $signed({2'b00, target_distance, 30'd0});
          c_y     <= {{18{num[45]}}, num};
          c_mode  <= CORDIC_VEC;
          st      <= S_TURN;
        end
        S_TURN: begin
          if (c_done) begin
            tang <= $signed(c_angle);
            st   <= S_MUL2;
          end
        end
        S_MUL2: begin
          mag <= tabs * kgain;
          st  <= S_RND;
        end
        S_RND: begin
          if (rnd > 19'(PPS_STEER_LIMIT)) begin
            steer <= (tang < 0) ? -$signed(PPS_STEER_LIMIT) : $signed(PPS_STEER_LIMIT);
          end else begin
            steer <= (tang < 0) ? -$signed(16'(rnd)) : $signed(16'(rnd));
          end
          st <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data.steer_angle   <= steer[14:0];
            out_data.speed_cmd     <= cfg.drive_speed;
            out_data.nearest_point <= 12'(nearest_index);
            out_data.target_point  <= 12'(target_index);
            out_valid              <= 1'b1;
            st                     <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/pure_pursuit_steering.sv -----
// pure_pursuit_steering: top level, configuration registers, front queue and back engine
// depends on pps_pkg, pps_front, pps_back (which holds pps_cordic)

// Pure pursuit steering. Load transactions (opcode 0) append a waypoint to the
// path store, up to MAX_POINTS; further loads are dropped and give no result.
// A pose transaction (opcode 1) gives exactly one result: the nearest waypoint
// (whole path on the first pose, a window of window_back behind and
// window_ahead ahead of the last nearest index afterwards, last stored point
// excluded), the first waypoint beyond the lookahead distance, and the steer
// angle in 1/128 degree with the configured speed. Each searched waypoint in
// both the nearest and the target search passes a registered path memory
// read, the difference, the squaring of x and y and the compare, so the first
// pose searches the whole store for the nearest waypoint and later poses at
// most window_back + 2 * window_ahead waypoints. On top come the target
// distance root when a new target is picked and the cordic passes: bearing,
// sine and steer angle with 24 steps each, bearing and steer angle after a
// normalizing shift; the steer angle pass is skipped at zero target distance.
// A pose on an empty path answers with a zero steer angle, without a search.
// A four entry queue keeps taking transactions while a pose is worked on, and
// a result register holds the answer until it is taken. The configuration
// port is always ready; write it only while the block is idle.

module pure_pursuit_steering import pps_pkg::*; #(
  parameter int MAX_POINTS = PPS_MAX_POINTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  assign cfg_ready = 1'b1;

  // configuration registers, out-of-range indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lookahead_dist <= 16'd768;
      cfg.wheelbase      <= 12'd266;
      cfg.steer_gain     <= 10'd358;
      cfg.drive_speed    <= 8'd10;
      cfg.window_back    <= 8'd30;
      cfg.window_ahead   <= 8'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOOKAHEAD:   cfg.lookahead_dist <= cfg_data;
        REG_WHEELBASE:   cfg.wheelbase      <= cfg_data[11:0];
        REG_STEER_GAIN:  cfg.steer_gain     <= cfg_data[9:0];
        REG_DRIVE_SPEED: cfg.drive_speed    <= cfg_data[7:0];
        REG_WINDOW_BACK: cfg.window_back    <= cfg_data[7:0];
        REG_WINDOW_AHD:  cfg.window_ahead   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // front: accept and tag each transaction, queue it
  pps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // back: path store, searches, steer computation and result register
  pps_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
